[sv/bmp_pkg.sv]
// Shared constants, types and job layout for the binomial modulo prime block.
`default_nettype none
package bmp_pkg;

    // Factorial table size and derived address width.
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    // Field widths of the stream items.
    localparam int IDX_W = 10;
    localparam int VAL_W = 30;

    // Modulus, Fermat exponent and Barrett constant.
    localparam logic [VAL_W-1:0] PRIME_MOD  = 30'd1000000007;
    localparam logic [VAL_W-1:0] FERMAT_EXP = 30'd1000000005;
    localparam int               EXP_BITS   = 30;
    localparam int               BIT_W      = $clog2(EXP_BITS);
    localparam logic [63:0]      MU_FULL    = (64'd1 << 60) / 64'd1000000007;
    localparam logic [30:0]      BARRETT_MU = MU_FULL[30:0];

    // Destination of a modular product in the back end.
    typedef enum logic {
        TAG_SQ,
        TAG_ACC
    } t_tag;

    // One classified item handed from the front to the back.
    typedef struct packed {
        logic             oor;
        logic             zero;
        logic [VAL_W-1:0] fn;
        logic [VAL_W-1:0] fr;
        logic [VAL_W-1:0] fnr;
    } t_job;

endpackage
`default_nettype wire

[sv/binomial_mod_prime.sv]
// The back end works on one item at a time, its pace set by the 30-bit Fermat exponentiation
// on the single four-stage modular multiplier (a square for every exponent bit and a further
// product for each set bit); an item with r above n skips the arithmetic. The front can take
// the next input while the back end is busy, as long as the queue has room. Reset: synchronous,
// active low; afterwards the factorial table is filled by the same multiplier, and no input is
// taken until it completes.
`default_nettype none
module binomial_mod_prime (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // n_value [9:0], r_value [19:10]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // binom_mod [29:0]
    output logic             m_axis_tuser    // out_of_range [0]
);
    import bmp_pkg::*;

    logic              w_fill_done;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [VAL_W-1:0]  w_wdata;
    logic [ADDR_W-1:0] w_raddr;
    logic [VAL_W-1:0]  w_rdata;
    logic              w_push;
    logic              w_pop;
    logic              w_full;
    logic              w_empty;
    t_job              w_fjob;
    t_job              w_qjob;

    // Factorial table.
    bmp_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Input side and factorial fetch.
    bmp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fill_done   (w_fill_done),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .o_raddr       (w_raddr),
        .i_rdata       (w_rdata),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_job         (w_fjob)
    );

    // Job queue between the two halves.
    bmp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_job   (w_qjob)
    );

    // Arithmetic and output side.
    bmp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .o_fill_done   (w_fill_done),
        .o_we          (w_we),
        .o_waddr       (w_waddr),
        .o_wdata       (w_wdata),
        .i_q_empty     (w_empty),
        .i_job         (w_qjob),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
`default_nettype wire

[sv/bmp_ram.sv]
// Generic single write port RAM with a registered read port.
`default_nettype none
module bmp_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[sv/bmp_front.sv]
// Front end: accepts n, r pairs, classifies them and fetches the factorials.
`default_nettype none
module bmp_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_fill_done,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [23:0]                  s_axis_tdata,   // n_value, r_value
    output logic      [bmp_pkg::ADDR_W-1:0]   o_raddr,
    input  wire logic [bmp_pkg::VAL_W-1:0]    i_rdata,
    input  wire logic                         i_q_full,
    output logic                              o_push,
    output bmp_pkg::t_job                     o_job
);
    import bmp_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE,
        F_RD_R,
        F_RD_NR,
        F_CAP,
        F_PUSH
    } t_fstate;

    t_fstate          r_state;
    logic [IDX_W-1:0] r_n;
    logic [IDX_W-1:0] r_r;
    t_job             r_job;
    logic [IDX_W-1:0] w_n;
    logic [IDX_W-1:0] w_r;
    logic [IDX_W-1:0] w_diff;
    logic             w_accept;

    assign w_n      = s_axis_tdata[IDX_W-1:0];
    assign w_r      = s_axis_tdata[2*IDX_W-1:IDX_W];
    assign w_diff   = r_n - r_r;
    assign s_axis_tready = (r_state == F_IDLE) && i_fill_done;
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign o_push   = (r_state == F_PUSH) && !i_q_full;
    assign o_job    = r_job;

    // Table read address for each fetch step.
    always_comb begin
        case (r_state)
            F_RD_R:  o_raddr = ADDR_W'(r_r);
            F_RD_NR: o_raddr = ADDR_W'(w_diff);
            default: o_raddr = ADDR_W'(w_n);
        endcase
    end

    // Sequencer that fetches n!, r! and (n-r)! one after another.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (w_accept) begin
                        r_n          <= w_n;
                        r_r          <= w_r;
                        r_job.oor    <= 32'(w_n) >= TABLE_DEPTH;
                        r_job.zero   <= w_r > w_n;
                        if ((32'(w_n) >= TABLE_DEPTH) || (w_r > w_n)) begin
                            r_state <= F_PUSH;
                        end else begin
                            r_state <= F_RD_R;
                        end
                    end
                end
                F_RD_R: begin
                    r_job.fn <= i_rdata;
                    r_state  <= F_RD_NR;
                end
                F_RD_NR: begin
                    r_job.fr <= i_rdata;
                    r_state  <= F_CAP;
                end
                F_CAP: begin
                    r_job.fnr <= i_rdata;
                    r_state   <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

[sv/bmp_queue.sv]
// Two-entry queue of classified jobs between the front and the back.
`default_nettype none
module bmp_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire bmp_pkg::t_job i_job,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_empty,
    output bmp_pkg::t_job      o_job
);
    import bmp_pkg::*;

    t_job       r_entry [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_job   = r_entry[r_rptr];

    // Pointer and fill count update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_job;
        end
    end

endmodule
`default_nettype wire

[sv/bmp_mulmod.sv]
// Four-stage modular multiplier with Barrett reduction modulo the prime.
`default_nettype none
module bmp_mulmod (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire bmp_pkg::t_tag              i_tag,
    input  wire logic [bmp_pkg::VAL_W-1:0]  i_a,
    input  wire logic [bmp_pkg::VAL_W-1:0]  i_b,
    output logic                            o_valid,
    output bmp_pkg::t_tag                   o_tag,
    output logic      [bmp_pkg::VAL_W-1:0]  o_res
);
    import bmp_pkg::*;

    logic [3:0]       r_vld;
    t_tag             r_tag [4];
    logic [59:0]      r_prod;
    logic [61:0]      r_q2;
    logic [31:0]      r_plo2;
    logic [31:0]      r_plo3;
    logic [31:0]      r_m;
    logic [VAL_W-1:0] r_res;
    logic [59:0]      w_prod;
    logic [61:0]      w_q2;
    logic [60:0]      w_m;
    logic [31:0]      w_x;
    logic [31:0]      w_p1;
    logic [31:0]      w_p2;

    assign w_prod = i_a * i_b;
    assign w_q2   = r_prod[59:29] * BARRETT_MU;
    assign w_m    = r_q2[61:31] * PRIME_MOD;
    assign w_x    = r_plo3 - r_m;
    assign w_p1   = 32'(PRIME_MOD);
    assign w_p2   = {w_p1[30:0], 1'b0};
    assign o_valid = r_vld[3];
    assign o_tag   = r_tag[3];
    assign o_res   = r_res;

    // Valid pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 4'd0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    // Product, quotient estimate, its multiple of p, and the final correction.
    always_ff @(posedge i_clk) begin
        r_tag[0] <= i_tag;
        r_tag[1] <= r_tag[0];
        r_tag[2] <= r_tag[1];
        r_tag[3] <= r_tag[2];
        r_prod   <= w_prod;
        r_q2     <= w_q2;
        r_plo2   <= r_prod[31:0];
        r_m      <= w_m[31:0];
        r_plo3   <= r_plo2;
        if (w_x >= w_p2) begin
            r_res <= VAL_W'(w_x - w_p2);
        end else if (w_x >= w_p1) begin
            r_res <= VAL_W'(w_x - w_p1);
        end else begin
            r_res <= VAL_W'(w_x);
        end
    end

endmodule
`default_nettype wire

[sv/bmp_back.sv]
// Back end: fills the factorial table, then inverts and multiplies per job.
`default_nettype none
module bmp_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    output logic                             o_fill_done,
    output logic                             o_we,
    output logic      [bmp_pkg::ADDR_W-1:0]  o_waddr,
    output logic      [bmp_pkg::VAL_W-1:0]   o_wdata,
    input  wire logic                        i_q_empty,
    input  wire bmp_pkg::t_job               i_job,
    output logic                             o_pop,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [31:0]                 m_axis_tdata,   // binom_mod
    output logic                             m_axis_tuser    // out_of_range
);
    import bmp_pkg::*;

    typedef enum logic [3:0] {
        B_FILL0,
        B_FILL_ISS,
        B_FILL_WAIT,
        B_IDLE,
        B_DEN_WAIT,
        B_EXP_SQ,
        B_EXP_MUL,
        B_EXP_WAIT,
        B_FIN,
        B_FIN_WAIT,
        B_OUT
    } t_bstate;

    t_bstate          r_state;
    logic             r_fill_done;
    logic [ADDR_W-1:0] r_k;
    logic [BIT_W-1:0] r_bit;
    logic [VAL_W-1:0] r_sq;
    logic [VAL_W-1:0] r_acc;
    logic [VAL_W-1:0] r_fn;
    logic [VAL_W-1:0] r_res;
    logic             r_res_oor;
    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_data;
    logic             r_out_oor;
    logic             w_mvalid;
    t_tag             w_mtag;
    logic [VAL_W-1:0] w_ma;
    logic [VAL_W-1:0] w_mb;
    logic             w_rvalid;
    t_tag             w_rtag;
    logic [VAL_W-1:0] w_rres;
    logic             w_bit_set;
    logic             w_job_work;

    assign w_bit_set  = FERMAT_EXP[r_bit];
    assign w_job_work = !i_q_empty && !i_job.oor && !i_job.zero;
    assign o_pop      = (r_state == B_IDLE) && !i_q_empty;
    assign o_fill_done = r_fill_done;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 32'(r_out_data);
    assign m_axis_tuser  = r_out_oor;

    // Table writes during the start-up fill.
    assign o_we    = (r_state == B_FILL0) || ((r_state == B_FILL_WAIT) && w_rvalid);
    assign o_waddr = (r_state == B_FILL0) ? '0 : r_k;
    assign o_wdata = (r_state == B_FILL0) ? VAL_W'(1) : w_rres;

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mvalid = 1'b0;
        w_mtag   = TAG_ACC;
        w_ma     = r_acc;
        w_mb     = r_sq;
        case (r_state)
            B_FILL_ISS: begin
                w_mvalid = 1'b1;
                w_mb     = VAL_W'(r_k);
            end
            B_IDLE: begin
                w_mvalid = w_job_work;
                w_mtag   = TAG_SQ;
                w_ma     = i_job.fr;
                w_mb     = i_job.fnr;
            end
            B_EXP_SQ: begin
                w_mvalid = 1'b1;
                w_mtag   = TAG_SQ;
                w_ma     = r_sq;
            end
            B_EXP_MUL: begin
                w_mvalid = 1'b1;
            end
            B_FIN: begin
                w_mvalid = 1'b1;
                w_ma     = r_fn;
                w_mb     = r_acc;
            end
            default: w_mvalid = 1'b0;
        endcase
    end

    bmp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mvalid),
        .i_tag   (w_mtag),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_valid (w_rvalid),
        .o_tag   (w_rtag),
        .o_res   (w_rres)
    );

    // Sequencer, working registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_FILL0;
            r_fill_done <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_rvalid) begin
                if (w_rtag == TAG_SQ) begin
                    r_sq <= w_rres;
                end else begin
                    r_acc <= w_rres;
                end
            end
            // The output register empties on a transfer unless it is reloaded below.
            if (m_axis_tready && (r_state != B_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_FILL0: begin
                    r_acc   <= VAL_W'(1);
                    r_k     <= ADDR_W'(1);
                    r_state <= B_FILL_ISS;
                end
                B_FILL_ISS: begin
                    r_state <= B_FILL_WAIT;
                end
                B_FILL_WAIT: begin
                    if (w_rvalid) begin
                        if (r_k == ADDR_W'(TABLE_DEPTH - 1)) begin
                            r_fill_done <= 1'b1;
                            r_state     <= B_IDLE;
                        end else begin
                            r_k     <= r_k + ADDR_W'(1);
                            r_state <= B_FILL_ISS;
                        end
                    end
                end
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_fn <= i_job.fn;
                        if (w_job_work) begin
                            r_state <= B_DEN_WAIT;
                        end else begin
                            r_res     <= '0;
                            r_res_oor <= i_job.oor;
                            r_state   <= B_OUT;
                        end
                    end
                end
                B_DEN_WAIT: begin
                    if (w_rvalid) begin
                        r_acc   <= VAL_W'(1);
                        r_bit   <= '0;
                        r_state <= B_EXP_SQ;
                    end
                end
                B_EXP_SQ: begin
                    r_state <= w_bit_set ? B_EXP_MUL : B_EXP_WAIT;
                end
                B_EXP_MUL: begin
                    r_state <= B_EXP_WAIT;
                end
                B_EXP_WAIT: begin
                    // The last product of this exponent bit closes the step.
                    if (w_rvalid && (w_rtag == (w_bit_set ? TAG_ACC : TAG_SQ))) begin
                        if (r_bit == BIT_W'(EXP_BITS - 1)) begin
                            r_state <= B_FIN;
                        end else begin
                            r_bit   <= r_bit + BIT_W'(1);
                            r_state <= B_EXP_SQ;
                        end
                    end
                end
                B_FIN: begin
                    r_state <= B_FIN_WAIT;
                end
                B_FIN_WAIT: begin
                    if (w_rvalid) begin
                        r_res     <= w_rres;
                        r_res_oor <= 1'b0;
                        r_state   <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res;
                        r_out_oor   <= r_res_oor;
                        r_state     <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // Once the table is filled it stays filled.
    a_fill_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_done |=> r_fill_done)
        else $error("factorial table lost its filled status");

    // Every delivered residue is reduced.
    a_out_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data < PRIME_MOD))
        else $error("result not reduced modulo the prime");

    // An out-of-range result carries zero.
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_oor) |-> (r_out_data == '0))
        else $error("out-of-range result is not zero");

    // Products only return while the sequencer waits for them.
    a_result_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rvalid |-> ((r_state == B_FILL_WAIT) || (r_state == B_DEN_WAIT) ||
                      (r_state == B_EXP_WAIT) || (r_state == B_FIN_WAIT)))
        else $error("modular product returned with no consumer");

endmodule
`default_nettype wire

[tb/tb_binomial_mod_prime.sv]
// Self-checking stream testbench for the binomial coefficient modulo prime block.
`default_nettype none
module tb_binomial_mod_prime;
    import bmp_pkg::*;

    localparam int        N_RANDOM  = 850;
    localparam longint    MOD_P     = 64'd1000000007;
    localparam longint    CYCLE_MAX = 64'd2500000;
    localparam int        LATENCY   = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;       // n_value [9:0], r_value [19:10]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;            // binom_mod [29:0]
    logic        m_axis_tuser;            // out_of_range [0]

    binomial_mod_prime dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    typedef struct packed {
        logic [VAL_W-1:0] binom;
        logic             oor;
    } t_binom_result;

    // Directed pairs; a known answer is typed in where it is obvious.
    typedef struct {
        logic [IDX_W-1:0] n;
        logic [IDX_W-1:0] r;
        logic             known;
        logic [VAL_W-1:0] binom;
    } t_pair_row;

    t_pair_row pair_rows[] = '{
        '{10'd0,    10'd0,    1'b1, 30'd1},
        '{10'd1,    10'd0,    1'b1, 30'd1},
        '{10'd1,    10'd1,    1'b1, 30'd1},
        '{10'd0,    10'd1,    1'b1, 30'd0},
        '{10'd0,    10'd1023, 1'b1, 30'd0},
        '{10'd5,    10'd2,    1'b1, 30'd10},
        '{10'd10,   10'd3,    1'b1, 30'd120},
        '{10'd1023, 10'd0,    1'b1, 30'd1},
        '{10'd1023, 10'd1023, 1'b1, 30'd1},
        '{10'd1023, 10'd1,    1'b1, 30'd1023},
        '{10'd1022, 10'd1023, 1'b1, 30'd0},
        '{10'd1023, 10'd511,  1'b0, 30'd0},
        '{10'd1000, 10'd500,  1'b0, 30'd0},
        '{10'd682,  10'd341,  1'b0, 30'd0},
        '{10'd341,  10'd682,  1'b1, 30'd0},
        '{10'd999,  10'd998,  1'b1, 30'd999},
        '{10'd512,  10'd256,  1'b0, 30'd0}
    };

    logic [VAL_W-1:0] fact_mod[TABLE_DEPTH];
    t_binom_result    expected_binoms[$];
    int               mismatch_count = 0;
    longint           cycle_count = 0;
    logic             hold_off = 1'b0;

    function automatic logic [VAL_W-1:0] mulmod(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
        longint unsigned prod;
        prod = longint'(a) * longint'(b);
        return VAL_W'(prod % MOD_P);
    endfunction

    // Fermat inverse by square-and-multiply, least significant bit first.
    function automatic t_binom_result predict_binom(logic [IDX_W-1:0] n, logic [IDX_W-1:0] r);
        t_binom_result    res;
        logic [VAL_W-1:0] acc, sq, den;
        logic [31:0]      e;
        res = '0;
        if (int'(n) >= TABLE_DEPTH) begin
            res.oor = 1'b1;
        end else if (r <= n) begin
            den = mulmod(fact_mod[r], fact_mod[n - r]);
            acc = VAL_W'(1);
            sq  = den;
            e   = 32'(MOD_P - 2);
            while (e != 0) begin
                if (e[0]) acc = mulmod(acc, sq);
                sq = mulmod(sq, sq);
                e  = e >> 1;
            end
            res.binom = mulmod(fact_mod[n], acc);
        end
        return res;
    endfunction

    // One transfer on the input side, with the sender's gap pattern.
    int burst_left = 0;
    task automatic send_pair(logic [IDX_W-1:0] n, logic [IDX_W-1:0] r);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, r, n};
        expected_binoms = {expected_binoms, predict_binom(n, r)};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_results();
        while (expected_binoms.size() != 0) @(posedge i_clk);
    endtask

    // Receiver stall pattern, with one long hold-off.
    always @(posedge i_clk) begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else
            case ($urandom_range(0, 3))
                0: m_axis_tready <= 1'b0;
                default: m_axis_tready <= 1'b1;
            endcase
    end

    // Result checking against the oldest expectation.
    always @(posedge i_clk) begin
        t_binom_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_binoms.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result binom=%0d oor=%0d",
                             m_axis_tdata[VAL_W-1:0], m_axis_tuser);
            end else begin
                want = expected_binoms.pop_front();
                if (m_axis_tdata[VAL_W-1:0] !== want.binom || m_axis_tuser !== want.oor) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected binom=%0d oor=%0d, got binom=%0d oor=%0d",
                                 want.binom, want.oor, m_axis_tdata[VAL_W-1:0],
                                 m_axis_tuser);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_MAX) begin
            $display("tb_binomial_mod_prime NOT OK");
            $finish;
        end
    end

    // Long receiver hold-off while the sender keeps offering.
    initial begin
        wait (i_rst_n);
        repeat (12000) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (3000) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        t_binom_result want;
        logic [IDX_W-1:0] n, r;
        fact_mod[0] = VAL_W'(1);
        for (int k = 1; k < TABLE_DEPTH; k++)
            fact_mod[k] = mulmod(fact_mod[k-1], VAL_W'(k));
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part; typed answers are checked against the predictor too.
        foreach (pair_rows[i]) begin
            want = predict_binom(pair_rows[i].n, pair_rows[i].r);
            if (pair_rows[i].known && want.binom != pair_rows[i].binom) begin
                mismatch_count++;
                $display("table row %0d: expected %0d, predicted %0d",
                         i, pair_rows[i].binom, want.binom);
            end
            send_pair(pair_rows[i].n, pair_rows[i].r);
        end
        s_axis_tvalid <= 1'b0;
        drain_results();

        // Random part, mostly with r not above n.
        for (int i = 0; i < N_RANDOM; i++) begin
            n = IDX_W'($urandom_range(0, 1023));
            if ($urandom_range(0, 4) == 0)
                r = IDX_W'($urandom_range(0, 1023));
            else
                r = IDX_W'($urandom_range(0, n));
            send_pair(n, r);
            if (i == N_RANDOM / 2) begin
                s_axis_tvalid <= 1'b0;
                drain_results();
            end
        end
        s_axis_tvalid <= 1'b0;
        drain_results();
        repeat (LATENCY) @(posedge i_clk);
        if (mismatch_count == 0 && expected_binoms.size() == 0)
            $display("tb_binomial_mod_prime OK");
        else
            $display("tb_binomial_mod_prime NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
